// ===== hdl/earliest_free_server_wait_tracker_assert.svh =====
// Assertion macros used by the tracker top level
`ifndef EARLIEST_FREE_SERVER_WAIT_TRACKER_ASSERT_SVH
`define EARLIEST_FREE_SERVER_WAIT_TRACKER_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define EFTW_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define EFTW_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/eftw_pkg.sv =====
// Types and constants of the earliest-free-server wait tracker
`default_nettype none
package eftw_pkg;

	localparam int TIME_W  = 24;
	localparam int SUM_W   = 32;
	localparam int CNT_W   = 24;
	localparam int NSRV_W  = 5;
	localparam int IDX_W   = 4;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_NUM_SERVERS    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WAIT_THRESHOLD = 1'd1;

	localparam logic [NSRV_W-1:0] NUM_SERVERS_RST    = 5'd16;
	localparam logic [TIME_W-1:0] WAIT_THRESHOLD_RST = 24'd10;

	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
	localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};
	localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};

	typedef struct packed {
		logic [TIME_W-1:0] arrival_time;
		logic [TIME_W-1:0] service_time;
	} job_t;

	// head of the request queue, as seen by the back end
	typedef struct packed {
		logic valid;
		job_t job;
	} queue_t;

	typedef struct packed {
		logic [IDX_W-1:0]  server_index;
		logic [TIME_W-1:0] wait_time;
		logic [SUM_W-1:0]  total_wait;
		logic [CNT_W-1:0]  long_waits;
		logic [CNT_W-1:0]  jobs_served;
	} res_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SCAN,
		BK_UPDATE
	} back_state_t;

endpackage
`default_nettype wire

// ===== hdl/eftw_job_if.sv =====
// Job request channel
`default_nettype none
interface eftw_job_if;
	logic                         valid;
	logic                         ready;
	logic [eftw_pkg::TIME_W-1:0] arrival_time;
	logic [eftw_pkg::TIME_W-1:0] service_time;

	modport source (output valid, output arrival_time, output service_time, input ready);
	modport sink   (input valid, input arrival_time, input service_time, output ready);
endinterface
`default_nettype wire

// ===== hdl/eftw_res_if.sv =====
// Result channel
`default_nettype none
interface eftw_res_if;
	logic                         valid;
	logic                         ready;
	logic [eftw_pkg::IDX_W-1:0]  server_index;
	logic [eftw_pkg::TIME_W-1:0] wait_time;
	logic [eftw_pkg::SUM_W-1:0]  total_wait;
	logic [eftw_pkg::CNT_W-1:0]  long_waits;
	logic [eftw_pkg::CNT_W-1:0]  jobs_served;

	modport source (output valid, output server_index, output wait_time, output total_wait,
		output long_waits, output jobs_served, input ready);
	modport sink   (input valid, input server_index, input wait_time, input total_wait,
		input long_waits, input jobs_served, output ready);
endinterface
`default_nettype wire

// ===== hdl/eftw_cfg_if.sv =====
// Configuration write channel
`default_nettype none
interface eftw_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [eftw_pkg::CFG_IDX_W-1:0]  index;
	logic [eftw_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/eftw_front.sv =====
// Front end: accepts job requests into a two-entry queue
`default_nettype none
module eftw_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	eftw_job_if.sink           job,
	output eftw_pkg::queue_t   q_out,
	input  wire logic          pop
);

	eftw_pkg::job_t slot_q [2];
	logic           wr_q;
	logic           rd_q;
	logic [1:0]     cnt_q;
	logic           push;
	logic           do_pop;

	assign job.ready = (cnt_q != 2'd2);
	assign push      = job.valid && job.ready;
	assign do_pop    = pop && (cnt_q != 2'd0);

	assign q_out.valid = (cnt_q != 2'd0);
	assign q_out.job   = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= ~wr_q;
			if (do_pop)
				rd_q <= ~rd_q;
			unique case ({push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q].arrival_time <= job.arrival_time;
			slot_q[wr_q].service_time <= job.service_time;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/eftw_back.sv =====
// Back end: scans server free times, updates the winner and the totals
`default_nettype none
module eftw_back #(
	parameter int SERVERS = 16,
	parameter int IW      = 4
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire eftw_pkg::queue_t             q_in,
	output logic                              pop,
	input  wire logic [IW-1:0]                last_idx,
	input  wire logic [eftw_pkg::TIME_W-1:0]  wait_threshold,
	eftw_res_if.source                        res
);

	localparam int XW = (IW > eftw_pkg::IDX_W) ? IW : eftw_pkg::IDX_W;

	eftw_pkg::back_state_t state_q, state_d;

	logic [eftw_pkg::TIME_W-1:0] mem [SERVERS];
	logic [SERVERS-1:0]          written_q;
	logic [IW-1:0]               rd_addr;
	logic [IW-1:0]               raddr_q;
	logic [eftw_pkg::TIME_W-1:0] rdata_q;
	logic                        rvalid_q;

	eftw_pkg::job_t              job_q;
	logic [eftw_pkg::TIME_W-1:0] best_free_q;
	logic [IW-1:0]               best_idx_q;

	logic [eftw_pkg::SUM_W-1:0]  wait_sum_q;
	logic [eftw_pkg::CNT_W-1:0]  long_cnt_q;
	logic [eftw_pkg::CNT_W-1:0]  job_cnt_q;

	logic                        res_valid_q;
	eftw_pkg::res_t              res_q;

	logic                        upd;
	logic                        out_free;
	logic [eftw_pkg::TIME_W-1:0] cur_free;
	logic                        take;
	logic                        scan_done;

	logic                        late;
	logic [eftw_pkg::TIME_W-1:0] wait_t;
	logic [eftw_pkg::TIME_W-1:0] start_t;
	logic [eftw_pkg::TIME_W:0]   done_t;
	logic [eftw_pkg::TIME_W-1:0] new_free;
	logic [eftw_pkg::SUM_W:0]    sum_t;
	logic [eftw_pkg::SUM_W-1:0]  new_sum;
	logic [eftw_pkg::CNT_W-1:0]  new_long;
	logic [eftw_pkg::CNT_W-1:0]  new_jobs;
	logic [XW-1:0]               idx_x;

	// never-written entries read as zero
	assign cur_free  = rvalid_q ? rdata_q : '0;
	assign take      = (raddr_q == '0) || (cur_free < best_free_q);
	assign scan_done = (raddr_q == last_idx);
	assign out_free  = !res_valid_q || res.ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			eftw_pkg::BK_IDLE:   if (q_in.valid) state_d = eftw_pkg::BK_SCAN;
			eftw_pkg::BK_SCAN:   if (scan_done) state_d = eftw_pkg::BK_UPDATE;
			eftw_pkg::BK_UPDATE: if (out_free) state_d = eftw_pkg::BK_IDLE;
			default:             state_d = eftw_pkg::BK_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		pop     = 1'b0;
		upd     = 1'b0;
		rd_addr = '0;
		unique case (state_q)
			eftw_pkg::BK_IDLE:   pop = q_in.valid;
			eftw_pkg::BK_SCAN:   rd_addr = raddr_q + IW'(1);
			eftw_pkg::BK_UPDATE: upd = out_free;
			default: ;
		endcase
	end

	// update datapath: start = max(free, arrival), free' = start + service
	always_comb begin
		late     = best_free_q > job_q.arrival_time;
		wait_t   = late ? (best_free_q - job_q.arrival_time) : '0;
		start_t  = late ? best_free_q : job_q.arrival_time;
		done_t   = {1'b0, start_t} + {1'b0, job_q.service_time};
		new_free = done_t[eftw_pkg::TIME_W] ? eftw_pkg::TIME_MAX : done_t[eftw_pkg::TIME_W-1:0];
		sum_t    = {1'b0, wait_sum_q} + (eftw_pkg::SUM_W + 1)'(wait_t);
		new_sum  = sum_t[eftw_pkg::SUM_W] ? eftw_pkg::SUM_MAX : sum_t[eftw_pkg::SUM_W-1:0];
		new_long = long_cnt_q;
		if ((wait_t > wait_threshold) && (long_cnt_q != eftw_pkg::CNT_MAX))
			new_long = long_cnt_q + eftw_pkg::CNT_W'(1);
		new_jobs = (job_cnt_q == eftw_pkg::CNT_MAX) ? job_cnt_q
			: job_cnt_q + eftw_pkg::CNT_W'(1);
	end

	assign idx_x = XW'(best_idx_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= eftw_pkg::BK_IDLE;
			written_q   <= '0;
			rvalid_q    <= 1'b0;
			wait_sum_q  <= '0;
			long_cnt_q  <= '0;
			job_cnt_q   <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			rvalid_q <= written_q[rd_addr];
			if (upd) begin
				written_q[best_idx_q] <= 1'b1;
				wait_sum_q            <= new_sum;
				long_cnt_q            <= new_long;
				job_cnt_q             <= new_jobs;
			end
			if (upd)
				res_valid_q <= 1'b1;
			else if (res.ready)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (upd)
			mem[best_idx_q] <= new_free;
		rdata_q <= mem[rd_addr];
		raddr_q <= rd_addr;
	end

	always_ff @(posedge clk) begin
		if (pop)
			job_q <= q_in.job;
		if (state_q == eftw_pkg::BK_SCAN && take) begin
			best_free_q <= cur_free;
			best_idx_q  <= raddr_q;
		end
		if (upd) begin
			res_q.server_index <= idx_x[eftw_pkg::IDX_W-1:0];
			res_q.wait_time    <= wait_t;
			res_q.total_wait   <= new_sum;
			res_q.long_waits   <= new_long;
			res_q.jobs_served  <= new_jobs;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.server_index = res_q.server_index;
	assign res.wait_time    = res_q.wait_time;
	assign res.total_wait   = res_q.total_wait;
	assign res.long_waits   = res_q.long_waits;
	assign res.jobs_served  = res_q.jobs_served;

endmodule
`default_nettype wire

// ===== hdl/earliest_free_server_wait_tracker.sv =====
// Top level of the earliest-free-server wait tracker
//
//  channel | dir | handshake    | payload
//  --------+-----+--------------+--------------------------------------------------
//  job     | in  | valid/ready  | arrival_time, service_time
//  res     | out | valid/ready  | server_index, wait_time, total_wait, long_waits,
//          |     |              | jobs_served
//  cfg     | in  | valid/ready  | index (0 num_servers, 1 wait_threshold), data
//
// In the back end a job is popped, then the free-time memory is scanned over
// the n active servers (one read port, one entry per cycle), then the winner
// is written back; the next job is popped only after that.
// Reset clears the totals and marks every free time as zero.
// Two requests queue ahead of the scan; a held result stalls only the write back.
`default_nettype none
`include "earliest_free_server_wait_tracker_assert.svh"
module earliest_free_server_wait_tracker #(
	parameter int SERVERS = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	eftw_job_if.sink   job,
	eftw_res_if.source res,
	eftw_cfg_if.sink   cfg
);

	localparam int IW = (SERVERS > 1) ? $clog2(SERVERS) : 1;

	logic [eftw_pkg::NSRV_W-1:0] num_servers_q;
	logic [eftw_pkg::TIME_W-1:0] wait_threshold_q;
	logic [IW-1:0]               last_idx;
	logic                        cfg_wr;
	logic                        nsrv_wr;
	eftw_pkg::queue_t            q_head;
	logic                        pop;

	assign cfg.ready = 1'b1;
	assign cfg_wr    = cfg.valid && cfg.ready;
	assign nsrv_wr   = cfg_wr && (cfg.index == eftw_pkg::REG_NUM_SERVERS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_servers_q    <= eftw_pkg::NUM_SERVERS_RST;
			wait_threshold_q <= eftw_pkg::WAIT_THRESHOLD_RST;
		end else if (cfg_wr) begin
			unique case (cfg.index)
				eftw_pkg::REG_NUM_SERVERS:
					num_servers_q <= cfg.data[eftw_pkg::NSRV_W-1:0];
				eftw_pkg::REG_WAIT_THRESHOLD:
					wait_threshold_q <= cfg.data[eftw_pkg::TIME_W-1:0];
				default: ;
			endcase
		end
	end

	// zero servers act as one; more than built act as all
	always_comb begin
		if (num_servers_q == '0)
			last_idx = '0;
		else if (int'(num_servers_q) > SERVERS)
			last_idx = IW'(SERVERS - 1);
		else
			last_idx = IW'(num_servers_q - eftw_pkg::NSRV_W'(1));
	end

	eftw_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.job    (job),
		.q_out  (q_head),
		.pop    (pop)
	);

	eftw_back #(
		.SERVERS (SERVERS),
		.IW      (IW)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_in           (q_head),
		.pop            (pop),
		.last_idx       (last_idx),
		.wait_threshold (wait_threshold_q),
		.res            (res)
	);

	`EFTW_ASSERT_NOW(a_jobs_nonzero, res.valid, res.jobs_served != '0, "zero job count")
	`EFTW_ASSERT_NOW(a_sum_ge_wait, res.valid, res.total_wait >= 32'(res.wait_time), "sum low")
	`EFTW_ASSERT_NOW(a_long_le_jobs, res.valid, res.long_waits <= res.jobs_served, "long > jobs")
	`EFTW_ASSERT_NEXT(a_cfg_num, nsrv_wr, num_servers_q == $past(cfg.data[4:0]), "write lost")

endmodule
`default_nettype wire
